/* hdl/sdoc_pkg.sv */
// Shared types and constants of the expedited SDO client.
`timescale 1ns / 1ps

package sdoc_pkg;

  // Default depth of the queue between the front and back parts
  localparam int QUEUE_DEPTH = 2;

  // Configuration register indexes and reset values
  localparam logic [0:0] CFG_SHORT_TIMEOUT = 1'd0;
  localparam logic [0:0] CFG_LONG_TIMEOUT  = 1'd1;
  localparam logic [7:0] SHORT_TIMEOUT_RST = 8'd15;
  localparam logic [7:0] LONG_TIMEOUT_RST  = 8'd50;

  // Input function codes
  localparam logic [1:0] FUNC_DOWNLOAD = 2'd0;
  localparam logic [1:0] FUNC_UPLOAD   = 2'd1;
  localparam logic [1:0] FUNC_FRAME    = 2'd2;
  localparam logic [1:0] FUNC_TICK     = 2'd3;

  // SDO command bytes
  localparam logic [7:0] CMD_UPLOAD_REQ = 8'h40;
  localparam logic [7:0] CMD_DL_UNSPEC  = 8'h22;
  localparam logic [7:0] CMD_DL_4       = 8'h23;
  localparam logic [7:0] CMD_DL_3       = 8'h27;
  localparam logic [7:0] CMD_DL_2       = 8'h2b;
  localparam logic [7:0] CMD_DL_1       = 8'h2f;
  localparam logic [7:0] CMD_ABORT      = 8'h80;
  localparam logic [7:0] CMD_DL_ACK     = 8'h60;
  localparam logic [7:0] CMD_UL_3       = 8'h47;
  localparam logic [7:0] CMD_UL_2       = 8'h4b;
  localparam logic [7:0] CMD_UL_1       = 8'h4f;
  localparam logic [3:0] CMD_DL_GROUP   = 4'h2;
  localparam logic [3:0] CMD_UL_GROUP   = 4'h4;

  // CAN identifiers of the SDO channels
  localparam logic [10:0] TX_ID_BASE = 11'h600;
  localparam logic [10:0] RX_ID_BASE = 11'h580;

  // Store and restore objects use the long timeout
  localparam logic [15:0] OBJ_STORE   = 16'h1010;
  localparam logic [15:0] OBJ_RESTORE = 16'h1011;

  // Transfer status codes
  localparam logic [1:0] STATUS_OK      = 2'd0;
  localparam logic [1:0] STATUS_ABORT   = 2'd1;
  localparam logic [1:0] STATUS_TIMEOUT = 2'd2;

  typedef enum logic [1:0] {
    KIND_REQUEST,
    KIND_FRAME,
    KIND_TICK
  } kind_t;

  // One classified item in flight between front and back
  typedef struct packed {
    kind_t       kind;
    logic [6:0]  node;
    logic [15:0] object;
    logic [7:0]  sub;
    logic [7:0]  cmd;      // request command or received command byte
    logic [31:0] payload;  // masked download value or received bytes 4..7
    logic [10:0] rx_id;
    logic        len_ok;   // received frame carries at least four bytes
  } entry_t;

  typedef struct packed {
    logic        tx_valid;
    logic [10:0] tx_id;
    logic [63:0] tx_data;
    logic        done_res;
    logic [1:0]  status;
    logic [31:0] read_data;
    logic [2:0]  read_len;
    logic [31:0] abort_code;
  } result_t;

endpackage

/* hdl/sdoc_front.sv */
// Front part: decode and classify one input transaction into a queue entry.
`timescale 1ns / 1ps

module sdoc_front import sdoc_pkg::*; (
  input  logic [1:0]  func,
  input  logic [6:0]  node_id,
  input  logic [15:0] object_index,
  input  logic [7:0]  sub_index,
  input  logic [2:0]  write_size,
  input  logic [31:0] write_data,
  input  logic [10:0] rx_id,
  input  logic [3:0]  rx_len,
  input  logic [63:0] rx_data,
  output entry_t      entry
);

  logic [7:0]  dl_cmd;
  logic [31:0] dl_mask;
  logic [31:0] rx_high;

  // Pick the download command and the bytes it carries
  always_comb begin
    case (write_size)
      3'd4:    begin dl_cmd = CMD_DL_4; dl_mask = 32'hffff_ffff; end
      3'd3:    begin dl_cmd = CMD_DL_3; dl_mask = 32'h00ff_ffff; end
      3'd2:    begin dl_cmd = CMD_DL_2; dl_mask = 32'h0000_ffff; end
      3'd1:    begin dl_cmd = CMD_DL_1; dl_mask = 32'h0000_00ff; end
      default: begin dl_cmd = CMD_DL_UNSPEC; dl_mask = 32'hffff_ffff; end
    endcase
  end

  // Drop received bytes at or beyond the frame length
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      rx_high[8*i +: 8] = (rx_len > 4'(i + 4)) ? rx_data[32 + 8*i +: 8] : 8'h00;
    end
  end

  // Build the entry for each kind of item
  always_comb begin
    entry        = '0;
    entry.rx_id  = rx_id;
    entry.len_ok = (rx_len >= 4'd4);
    case (func)
      FUNC_DOWNLOAD: begin
        entry.kind    = KIND_REQUEST;
        entry.node    = node_id;
        entry.object  = object_index;
        entry.sub     = sub_index;
        entry.cmd     = dl_cmd;
        entry.payload = write_data & dl_mask;
      end
      FUNC_UPLOAD: begin
        entry.kind    = KIND_REQUEST;
        entry.node    = node_id;
        entry.object  = object_index;
        entry.sub     = sub_index;
        entry.cmd     = CMD_UPLOAD_REQ;
        entry.payload = '0;
      end
      FUNC_FRAME: begin
        entry.kind    = KIND_FRAME;
        entry.cmd     = rx_data[7:0];
        entry.object  = rx_data[23:8];
        entry.sub     = rx_data[31:24];
        entry.payload = rx_high;
      end
      default: begin
        entry.kind = KIND_TICK;
      end
    endcase
  end

endmodule

/* hdl/sdoc_queue.sv */
// Short register queue between the front and back parts.
`timescale 1ns / 1ps

module sdoc_queue import sdoc_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  entry_t push_data,
  output logic   full,
  input  logic   pop,
  output logic   not_empty,
  output entry_t pop_data
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);

  entry_t          slots [DEPTH];
  logic [PW-1:0]   wr_ptr;
  logic [PW-1:0]   rd_ptr;
  logic [CW-1:0]   count;
  logic            do_push;
  logic            do_pop;

  assign full      = (count == CW'(DEPTH));
  assign not_empty = (count != '0);
  assign pop_data  = slots[rd_ptr];
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;

  // Store entries
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

/* hdl/sdoc_back.sv */
// Back part: transfer state, response checks, timeout and result register.
`timescale 1ns / 1ps

module sdoc_back import sdoc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [7:0]  cfg_data,
  input  logic        q_valid,
  input  entry_t      q_data,
  output logic        q_pop,
  output logic        out_valid,
  input  logic        out_ready,
  output result_t     out_data
);

  logic [7:0]  short_timeout;
  logic [7:0]  long_timeout;
  logic        busy;
  logic [6:0]  pending_command;
  logic [6:0]  pending_node;
  logic [15:0] pending_object;
  logic [7:0]  pending_subindex;
  logic [7:0]  tick_count;

  logic        busy_next;
  logic [6:0]  pending_command_next;
  logic [6:0]  pending_node_next;
  logic [15:0] pending_object_next;
  logic [7:0]  pending_subindex_next;
  logic [7:0]  tick_count_next;
  logic        has_res;
  result_t     res;

  logic [7:0]  limit;
  logic        id_match;
  logic        target_match;
  logic [2:0]  ul_len;
  logic [31:0] ul_mask;

  assign q_pop = q_valid && (!out_valid || out_ready);

  assign limit = (pending_object == OBJ_STORE || pending_object == OBJ_RESTORE)
               ? long_timeout : short_timeout;
  assign id_match     = (q_data.rx_id == (RX_ID_BASE | {4'b0, pending_node}));
  assign target_match = (q_data.object == pending_object) &&
                        (q_data.sub == pending_subindex);

  // Upload response byte count
  always_comb begin
    case (q_data.cmd)
      CMD_UL_3: begin ul_len = 3'd3; ul_mask = 32'h00ff_ffff; end
      CMD_UL_2: begin ul_len = 3'd2; ul_mask = 32'h0000_ffff; end
      CMD_UL_1: begin ul_len = 3'd1; ul_mask = 32'h0000_00ff; end
      default:  begin ul_len = 3'd4; ul_mask = 32'hffff_ffff; end
    endcase
  end

  // Carry out the item at the head of the queue
  always_comb begin
    busy_next             = busy;
    pending_command_next  = pending_command;
    pending_node_next     = pending_node;
    pending_object_next   = pending_object;
    pending_subindex_next = pending_subindex;
    tick_count_next       = tick_count;
    has_res               = 1'b0;
    res                   = '0;
    case (q_data.kind)
      KIND_REQUEST: begin
        busy_next             = 1'b1;
        pending_command_next  = q_data.cmd[6:0];
        pending_node_next     = q_data.node;
        pending_object_next   = q_data.object;
        pending_subindex_next = q_data.sub;
        tick_count_next       = '0;
        has_res               = 1'b1;
        res.tx_valid          = 1'b1;
        res.tx_id             = TX_ID_BASE | {4'b0, q_data.node};
        res.tx_data           = {q_data.payload, q_data.sub, q_data.object, q_data.cmd};
      end
      KIND_FRAME: begin
        if (busy && id_match && q_data.len_ok) begin
          if (q_data.cmd == CMD_ABORT) begin
            has_res        = 1'b1;
            res.status     = STATUS_ABORT;
            res.abort_code = q_data.payload;
          end else if (target_match) begin
            if (pending_command[6:4] == CMD_DL_GROUP[2:0] && q_data.cmd == CMD_DL_ACK) begin
              has_res    = 1'b1;
              res.status = STATUS_OK;
            end else if (pending_command == CMD_UPLOAD_REQ[6:0] &&
                         q_data.cmd[7:4] == CMD_UL_GROUP) begin
              has_res       = 1'b1;
              res.status    = STATUS_OK;
              res.read_data = q_data.payload & ul_mask;
              res.read_len  = ul_len;
            end
          end
        end
      end
      default: begin
        if (busy) begin
          if (tick_count >= limit) begin
            has_res    = 1'b1;
            res.status = STATUS_TIMEOUT;
          end else begin
            tick_count_next = tick_count + 8'd1;
          end
        end
      end
    endcase
    // A finishing result closes the transfer
    if (has_res && !res.tx_valid) begin
      res.done_res    = 1'b1;
      busy_next       = 1'b0;
      tick_count_next = '0;
    end
  end

  // Hold configuration, transfer state and the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      short_timeout    <= SHORT_TIMEOUT_RST;
      long_timeout     <= LONG_TIMEOUT_RST;
      busy             <= 1'b0;
      pending_command  <= '0;
      pending_node     <= '0;
      pending_object   <= '0;
      pending_subindex <= '0;
      tick_count       <= '0;
      out_valid        <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_SHORT_TIMEOUT: short_timeout <= cfg_data;
          CFG_LONG_TIMEOUT:  long_timeout  <= cfg_data;
          default:           ;
        endcase
      end
      if (q_pop) begin
        busy             <= busy_next;
        pending_command  <= pending_command_next;
        pending_node     <= pending_node_next;
        pending_object   <= pending_object_next;
        pending_subindex <= pending_subindex_next;
        tick_count       <= tick_count_next;
      end
      // Fill the result register, or free it once taken
      if (q_pop && has_res) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Load result payload
  always_ff @(posedge clk) begin
    if (q_pop && has_res) begin
      out_data <= res;
    end
  end

endmodule

/* hdl/sdo_expedited_client_core.sv */
// Top level of the CANopen expedited SDO client.
`timescale 1ns / 1ps

// Client side of an expedited SDO transfer. Download and upload requests each
// return one result holding the request frame to 0x600+node; received frames
// from 0x580+node and tick items are checked against the outstanding transfer
// and return a finishing result (success, server abort or timeout) or nothing.
// The block takes one transaction per clock cycle unless the output stalls:
// a decode stage classifies each item into a small register queue, and the
// back part retires one item per cycle against the transfer state while the
// output register is free or taken. Results are registered from the queue
// head; in a stall the queue takes input until it fills. The user must write
// timeout registers through the cfg port only while idle; it is not enforced.
module sdo_expedited_client_core import sdoc_pkg::*; #(
  parameter int QDEPTH = QUEUE_DEPTH
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_we,
  input  logic [0:0]   cfg_index,
  input  logic [7:0]   cfg_data,
  input  logic         s_tvalid,
  output logic         s_tready,
  // node_id[6:0], object_index[22:7], sub_index[30:23], write_size[33:31],
  // write_data[65:34], rx_id[76:66], rx_len[80:77], rx_data[144:81], zero pad
  input  logic [151:0] s_tdata,
  input  logic [1:0]   s_tuser,  // func[1:0]
  output logic         m_tvalid,
  input  logic         m_tready,
  // tx_id[10:0], tx_data[74:11], status[76:75], read_data[108:77],
  // read_len[111:109], abort_code[143:112]
  output logic [143:0] m_tdata,
  output logic [1:0]   m_tuser   // tx_valid[0], done_res[1]
);

  entry_t  front_entry;
  entry_t  q_head;
  logic    q_full;
  logic    q_valid;
  logic    q_pop;
  result_t res;

  sdoc_front u_front (
    .func         (s_tuser),
    .node_id      (s_tdata[6:0]),
    .object_index (s_tdata[22:7]),
    .sub_index    (s_tdata[30:23]),
    .write_size   (s_tdata[33:31]),
    .write_data   (s_tdata[65:34]),
    .rx_id        (s_tdata[76:66]),
    .rx_len       (s_tdata[80:77]),
    .rx_data      (s_tdata[144:81]),
    .entry        (front_entry)
  );

  sdoc_queue #(
    .DEPTH (QDEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (s_tvalid),
    .push_data (front_entry),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_valid),
    .pop_data  (q_head)
  );

  sdoc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_valid   (q_valid),
    .q_data    (q_head),
    .q_pop     (q_pop),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (res)
  );

  assign s_tready = !q_full;
  assign m_tdata  = {res.abort_code, res.read_len, res.read_data, res.status,
                     res.tx_data, res.tx_id};
  assign m_tuser  = {res.done_res, res.tx_valid};

endmodule

/* test/tb.sv */
// Self-checking testbench of the expedited SDO client core.
`timescale 1ns / 1ps

module tb;
  import sdoc_pkg::*;

  // One input transaction, unpacked
  typedef struct {
    logic [1:0]  func;
    logic [6:0]  node;
    logic [15:0] obj;
    logic [7:0]  sub;
    logic [2:0]  wsize;
    logic [31:0] wdata;
    logic [10:0] rx_id;
    logic [3:0]  rx_len;
    logic [63:0] rx_data;
  } sdo_item_t;

  localparam int IDLE_LIMIT  = 1000;
  localparam int DRAIN_WAIT  = 10;
  localparam int PHASE_ITEMS = 185;

  logic         clk;
  logic         rst = 1'b1;
  logic         cfg_we = 1'b0;
  logic [0:0]   cfg_index = CFG_SHORT_TIMEOUT;
  logic [7:0]   cfg_data = 8'd0;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [151:0] s_tdata = '0;
  logic [1:0]   s_tuser = FUNC_DOWNLOAD;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [143:0] m_tdata;
  logic [1:0]   m_tuser;

  sdo_item_t pending_items[$];
  result_t   expected_results[$];
  sdo_item_t in_item;

  int items_made = 0;
  int items_in = 0;
  int mismatch_count = 0;
  int idle_cycles = 0;

  // Timeout settings as the stimulus side knows them
  logic [7:0] gen_short = SHORT_TIMEOUT_RST;
  logic [7:0] gen_long = LONG_TIMEOUT_RST;

  // Predicted transfer state and timeout registers
  logic       xfer_busy;
  logic [7:0] xfer_cmd;
  logic [6:0] xfer_node;
  logic [15:0] xfer_obj;
  logic [7:0] xfer_sub;
  logic [7:0] xfer_ticks;
  logic [7:0] short_lim;
  logic [7:0] long_lim;

  sdo_expedited_client_core dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tuser(m_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic logic [63:0] low_bytes(input int n);
    logic [63:0] m;
    m = '0;
    for (int i = 0; i < 8; i++)
      if (i < n) m[8*i +: 8] = 8'hff;
    return m;
  endfunction

  // Work out the result of one accepted transaction and advance the state
  function automatic bit predict_response(input sdo_item_t it, output result_t res);
    logic [7:0]  cmd;
    logic [7:0]  limit;
    logic [63:0] keep;
    logic [63:0] rx;
    int          nbytes;
    res = '0;
    if (it.func == FUNC_DOWNLOAD || it.func == FUNC_UPLOAD) begin
      if (it.func == FUNC_UPLOAD) begin
        cmd = CMD_UPLOAD_REQ;
        nbytes = 0;
      end else begin
        case (it.wsize)
          3'd4: begin cmd = CMD_DL_4; nbytes = 4; end
          3'd3: begin cmd = CMD_DL_3; nbytes = 3; end
          3'd2: begin cmd = CMD_DL_2; nbytes = 2; end
          3'd1: begin cmd = CMD_DL_1; nbytes = 1; end
          default: begin cmd = CMD_DL_UNSPEC; nbytes = 4; end
        endcase
      end
      // A new request replaces whatever was outstanding
      xfer_busy = 1'b1;
      xfer_cmd = cmd;
      xfer_node = it.node;
      xfer_obj = it.obj;
      xfer_sub = it.sub;
      xfer_ticks = 8'd0;
      keep = low_bytes(nbytes);
      res.tx_valid = 1'b1;
      res.tx_id = TX_ID_BASE | {4'd0, it.node};
      res.tx_data = {it.wdata & keep[31:0], it.sub, it.obj, cmd};
      return 1'b1;
    end
    if (!xfer_busy) return 1'b0;
    if (it.func == FUNC_TICK) begin
      limit = (xfer_obj == OBJ_STORE || xfer_obj == OBJ_RESTORE) ? long_lim : short_lim;
      if (xfer_ticks < limit) begin
        xfer_ticks++;
        return 1'b0;
      end
      res.status = STATUS_TIMEOUT;
    end else begin
      if (it.rx_id != (RX_ID_BASE | {4'd0, xfer_node}) || it.rx_len < 4) return 1'b0;
      // Bytes past the frame length read as zero
      keep = low_bytes(it.rx_len > 8 ? 8 : it.rx_len);
      rx = it.rx_data & keep;
      if (rx[7:0] == CMD_ABORT) begin
        res.status = STATUS_ABORT;
        res.abort_code = rx[63:32];
      end else if (rx[23:8] != xfer_obj || rx[31:24] != xfer_sub) begin
        return 1'b0;
      end else if (xfer_cmd[7:4] == CMD_DL_GROUP && rx[7:0] == CMD_DL_ACK) begin
        res.status = STATUS_OK;
      end else if (xfer_cmd == CMD_UPLOAD_REQ && rx[7:4] == CMD_UL_GROUP) begin
        case (rx[7:0])
          CMD_UL_3: nbytes = 3;
          CMD_UL_2: nbytes = 2;
          CMD_UL_1: nbytes = 1;
          default: nbytes = 4;
        endcase
        keep = low_bytes(nbytes);
        res.status = STATUS_OK;
        res.read_data = rx[63:32] & keep[31:0];
        res.read_len = 3'(nbytes);
      end else begin
        return 1'b0;
      end
    end
    res.done_res = 1'b1;
    xfer_busy = 1'b0;
    xfer_ticks = 8'd0;
    return 1'b1;
  endfunction

  task automatic check_field(input string field, input logic [63:0] want,
                             input logic [63:0] seen);
    if (want !== seen) begin
      if (mismatch_count < 10)
        $display("mismatch on %s: expected %h, got %h", field, want, seen);
      mismatch_count++;
    end
  endtask

  // Stimulus builders
  function automatic sdo_item_t random_item();
    sdo_item_t it;
    it.func = 2'($urandom_range(0, 3));
    it.node = 7'($urandom_range(0, 127));
    it.obj = 16'($urandom);
    it.sub = 8'($urandom);
    it.wsize = 3'($urandom_range(0, 7));
    it.wdata = $urandom;
    it.rx_id = 11'($urandom_range(0, 2047));
    it.rx_len = 4'($urandom_range(0, 15));
    it.rx_data = {$urandom, $urandom};
    return it;
  endfunction

  function automatic sdo_item_t make_request(input logic [1:0] func, input logic [6:0] node,
                                             input logic [15:0] obj, input logic [7:0] sub,
                                             input logic [2:0] wsize, input logic [31:0] wdata);
    sdo_item_t it;
    it = random_item();
    it.func = func;
    it.node = node;
    it.obj = obj;
    it.sub = sub;
    it.wsize = wsize;
    it.wdata = wdata;
    return it;
  endfunction

  function automatic sdo_item_t make_frame(input logic [6:0] node, input logic [7:0] cmd,
                                           input logic [15:0] obj, input logic [7:0] sub,
                                           input logic [3:0] len, input logic [31:0] hi);
    sdo_item_t it;
    it = random_item();
    it.func = FUNC_FRAME;
    it.rx_id = RX_ID_BASE | {4'd0, node};
    it.rx_len = len;
    it.rx_data = {hi, sub, obj, cmd};
    return it;
  endfunction

  function automatic logic [7:0] success_cmd(input sdo_item_t req);
    if (req.func == FUNC_DOWNLOAD) return CMD_DL_ACK;
    case ($urandom_range(0, 5))
      0: return CMD_UL_3;
      1: return CMD_UL_2;
      2: return CMD_UL_1;
      default: return {CMD_UL_GROUP, 4'($urandom_range(0, 15))};
    endcase
  endfunction

  // A frame or tick that must leave the transfer waiting (mostly)
  function automatic sdo_item_t noise_item(input sdo_item_t req);
    sdo_item_t it;
    it = make_frame(req.node, success_cmd(req), req.obj, req.sub,
                    4'($urandom_range(4, 15)), $urandom);
    case ($urandom_range(0, 5))
      0: it.func = FUNC_TICK;
      1: it.rx_id = it.rx_id ^ 11'($urandom_range(1, 2047));
      2: it.rx_len = 4'($urandom_range(0, 3));
      3: it.rx_data[31:8] = it.rx_data[31:8] ^ 24'($urandom_range(1, 24'hffffff));
      4: it.rx_data[7:0] = (req.func == FUNC_UPLOAD) ? CMD_DL_ACK
                         : {CMD_UL_GROUP, 4'($urandom_range(0, 15))};
      default: it.rx_data[7:0] = 8'($urandom_range(0, 255));
    endcase
    return it;
  endfunction

  task automatic add_item(input sdo_item_t it);
    pending_items.push_back(it);
    items_made++;
  endtask

  // Request, some noise, then an ending: reply, abort, timeout or none
  task automatic add_transfer();
    sdo_item_t req;
    sdo_item_t tick_it;
    logic [7:0] limit;
    req = random_item();
    req.func = $urandom_range(0, 1) ? FUNC_UPLOAD : FUNC_DOWNLOAD;
    case ($urandom_range(0, 9))
      0: req.obj = OBJ_STORE;
      1: req.obj = OBJ_RESTORE;
      default: ;
    endcase
    add_item(req);
    repeat ($urandom_range(0, 3)) add_item(noise_item(req));
    tick_it = random_item();
    tick_it.func = FUNC_TICK;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5:
        add_item(make_frame(req.node, success_cmd(req), req.obj, req.sub,
                            4'($urandom_range(4, 15)), $urandom));
      6, 7:
        add_item(make_frame(req.node, CMD_ABORT, $urandom_range(0, 1) ? req.obj : 16'($urandom),
                            8'($urandom), 4'($urandom_range(4, 15)), $urandom));
      8: begin
        limit = (req.obj == OBJ_STORE || req.obj == OBJ_RESTORE) ? gen_long : gen_short;
        if (limit <= 40 || $urandom_range(0, 19) == 0)
          repeat (int'(limit) + 1) add_item(tick_it);
      end
      default: ;
    endcase
  endtask

  task automatic run_random_phase(input int quota);
    int first;
    first = items_made;
    while (items_made - first < quota) begin
      if ($urandom_range(0, 9) == 0) add_item(random_item());
      else add_transfer();
    end
  endtask

  // Wait until every transaction is through and the pipeline has emptied
  task automatic drain();
    while (pending_items.size() != 0 || s_tvalid || expected_results.size() != 0)
      @(negedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic write_timeouts(input logic [7:0] short_val, input logic [7:0] long_val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= CFG_SHORT_TIMEOUT;
    cfg_data <= short_val;
    @(posedge clk);
    cfg_index <= CFG_LONG_TIMEOUT;
    cfg_data <= long_val;
    @(posedge clk);
    cfg_we <= 1'b0;
    gen_short = short_val;
    gen_long = long_val;
  endtask

  // Stimulus sequence
  initial begin
    // Idle traffic, then every download size with extreme fields
    add_item(make_request(FUNC_TICK, 7'd0, 16'd0, 8'd0, 3'd0, 32'd0));
    add_item(make_frame(7'd0, CMD_DL_ACK, 16'd0, 8'd0, 4'd8, 32'd0));
    add_item(make_request(FUNC_DOWNLOAD, 7'h7f, 16'hffff, 8'hff, 3'd4, 32'hffffffff));
    add_item(make_request(FUNC_DOWNLOAD, 7'h00, 16'h0000, 8'h00, 3'd1, 32'hffffffff));
    add_item(make_request(FUNC_DOWNLOAD, 7'h55, 16'ha5a5, 8'h5a, 3'd2, 32'h12345678));
    add_item(make_request(FUNC_DOWNLOAD, 7'h2a, 16'h5a5a, 8'ha5, 3'd3, 32'hffffffff));
    add_item(make_request(FUNC_DOWNLOAD, 7'h2a, 16'h5a5a, 8'ha5, 3'd0, 32'hcafef00d));
    add_item(make_request(FUNC_DOWNLOAD, 7'h2a, 16'h5a5a, 8'ha5, 3'd5, 32'hffffffff));
    add_item(make_request(FUNC_DOWNLOAD, 7'h2a, 16'h5a5a, 8'ha5, 3'd6, 32'h00000000));
    add_item(make_request(FUNC_DOWNLOAD, 7'h2a, 16'h5a5a, 8'ha5, 3'd7, 32'hffffffff));
    // Short frame and wrong object are dropped, then a long acknowledge
    add_item(make_frame(7'h2a, CMD_DL_ACK, 16'h5a5a, 8'ha5, 4'd3, 32'd0));
    add_item(make_frame(7'h2a, CMD_DL_ACK, 16'h5a5b, 8'ha5, 4'd8, 32'd0));
    add_item(make_frame(7'h2a, CMD_DL_ACK, 16'h5a5a, 8'ha5, 4'd15, 32'hffffffff));
    // Uploads with each response length
    add_item(make_request(FUNC_UPLOAD, 7'd1, OBJ_STORE, 8'd0, 3'd0, 32'd0));
    add_item(make_request(FUNC_TICK, 7'd0, 16'd0, 8'd0, 3'd0, 32'd0));
    add_item(make_frame(7'd1, CMD_UL_1, OBJ_STORE, 8'd0, 4'd5, 32'hffffffff));
    add_item(make_request(FUNC_UPLOAD, 7'd2, OBJ_RESTORE, 8'd2, 3'd0, 32'd0));
    add_item(make_frame(7'd2, CMD_UL_3, OBJ_RESTORE, 8'd2, 4'd8, 32'hffffffff));
    add_item(make_request(FUNC_UPLOAD, 7'd3, 16'h2000, 8'd1, 3'd0, 32'd0));
    add_item(make_frame(7'd3, CMD_UL_2, 16'h2000, 8'd1, 4'd6, 32'hffffffff));
    add_item(make_request(FUNC_UPLOAD, 7'd4, 16'h2001, 8'd9, 3'd0, 32'd0));
    add_item(make_frame(7'd4, CMD_UPLOAD_REQ | 8'h03, 16'h2001, 8'd9, 4'd8, 32'hffffffff));
    // Unexpected command is dropped; aborts end uploads and downloads
    add_item(make_request(FUNC_UPLOAD, 7'd9, 16'h6000, 8'd3, 3'd0, 32'd0));
    add_item(make_frame(7'd9, CMD_DL_ACK, 16'h6000, 8'd3, 4'd8, 32'd0));
    add_item(make_frame(7'd9, CMD_ABORT, 16'h1234, 8'd7, 4'd8, 32'hffffffff));
    add_item(make_request(FUNC_DOWNLOAD, 7'd9, 16'h6000, 8'd3, 3'd4, 32'h01020304));
    add_item(make_frame(7'd9, CMD_ABORT, 16'h6000, 8'd3, 4'd6, 32'hffffffff));

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    run_random_phase(PHASE_ITEMS);
    drain();
    write_timeouts(8'd1, 8'd255);
    run_random_phase(PHASE_ITEMS);
    drain();
    write_timeouts(8'd255, 8'd1);
    run_random_phase(PHASE_ITEMS);
    drain();
    write_timeouts(8'd4, 8'd12);
    run_random_phase(PHASE_ITEMS);
    drain();
    write_timeouts(8'd1, 8'd1);
    run_random_phase(PHASE_ITEMS);
    drain();

    if (mismatch_count == 0)
      $display("sdo_expedited_client_core verification clean");
    else
      $display("sdo_expedited_client_core verification failed");
    $finish;
  end

  // Driver: feed pending transactions in bursts with gaps
  int burst_left = 0;
  int gap_left = 0;
  sdo_item_t nxt;

  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      burst_left <= 0;
      gap_left <= 0;
    end else if (!s_tvalid || s_tready) begin
      if (gap_left != 0) begin
        s_tvalid <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (pending_items.size() != 0) begin
        nxt = pending_items.pop_front();
        in_item <= nxt;
        s_tdata <= {7'd0, nxt.rx_data, nxt.rx_len, nxt.rx_id, nxt.wdata, nxt.wsize,
                    nxt.sub, nxt.obj, nxt.node};
        s_tuser <= nxt.func;
        s_tvalid <= 1'b1;
        if (burst_left == 0) begin
          burst_left <= $urandom_range(1, 48);
          gap_left <= $urandom_range(0, 6);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: stall pattern plus a few long hold-offs to back up the input
  int ready_phase = 0;
  int hold_left = 0;
  int holds_done = 0;

  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      ready_phase <= 0;
      hold_left <= 0;
      holds_done <= 0;
    end else if (hold_left != 0) begin
      m_tready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (holds_done < 3 && items_in >= 150 * (holds_done + 1)) begin
      m_tready <= 1'b0;
      hold_left <= 80;
      holds_done <= holds_done + 1;
    end else begin
      ready_phase <= (ready_phase + 1) % 100;
      if (ready_phase < 30) m_tready <= 1'b1;
      else if (ready_phase < 70) m_tready <= ($urandom_range(0, 3) != 0);
      else m_tready <= ready_phase[0];
    end
  end

  // Monitor: predict on input transactions, compare output transactions
  result_t want_res;
  result_t got_res;

  always @(posedge clk) begin
    if (rst) begin
      xfer_busy = 1'b0;
      xfer_cmd = 8'd0;
      xfer_node = 7'd0;
      xfer_obj = 16'd0;
      xfer_sub = 8'd0;
      xfer_ticks = 8'd0;
      short_lim = SHORT_TIMEOUT_RST;
      long_lim = LONG_TIMEOUT_RST;
      items_in <= 0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_SHORT_TIMEOUT) short_lim = cfg_data;
        else long_lim = cfg_data;
      end
      if (s_tvalid && s_tready) begin
        items_in <= items_in + 1;
        if (predict_response(in_item, want_res)) expected_results.push_back(want_res);
      end
      if (m_tvalid && m_tready) begin
        got_res.tx_valid = m_tuser[0];
        got_res.done_res = m_tuser[1];
        got_res.tx_id = m_tdata[10:0];
        got_res.tx_data = m_tdata[74:11];
        got_res.status = m_tdata[76:75];
        got_res.read_data = m_tdata[108:77];
        got_res.read_len = m_tdata[111:109];
        got_res.abort_code = m_tdata[143:112];
        if (expected_results.size() == 0) begin
          if (mismatch_count < 10)
            $display("unexpected result: tx_valid %b tx_id %h tx_data %h done %b status %0d",
                     got_res.tx_valid, got_res.tx_id, got_res.tx_data, got_res.done_res,
                     got_res.status);
          mismatch_count++;
        end else begin
          want_res = expected_results.pop_front();
          check_field("tx_valid", 64'(want_res.tx_valid), 64'(got_res.tx_valid));
          check_field("tx_id", 64'(want_res.tx_id), 64'(got_res.tx_id));
          check_field("tx_data", want_res.tx_data, got_res.tx_data);
          check_field("done_res", 64'(want_res.done_res), 64'(got_res.done_res));
          check_field("status", 64'(want_res.status), 64'(got_res.status));
          check_field("read_data", 64'(want_res.read_data), 64'(got_res.read_data));
          check_field("read_len", 64'(want_res.read_len), 64'(got_res.read_len));
          check_field("abort_code", 64'(want_res.abort_code), 64'(got_res.abort_code));
        end
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("sdo_expedited_client_core verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule

/* filelist.f */
hdl/sdoc_pkg.sv
hdl/sdoc_front.sv
hdl/sdoc_queue.sv
hdl/sdoc_back.sv
hdl/sdo_expedited_client_core.sv
test/tb.sv
